// File: sv/edpd_pkg.sv
// ----------------------------------------------------------------------------
// edpd_pkg: shared types and constants for edwards25519 point decompression
// Field constants, working-set slot map, micro-program and exponent bits.
// ----------------------------------------------------------------------------
package edpd_pkg;

	localparam int FE_W = 255;
	localparam int SLOT_W = 4;
	localparam int PC_W = 4;
	localparam int BIT_W = 8;

	// Field prime p = 2^255 - 19.
	localparam logic [FE_W-1:0] P =
		255'h7fffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffed;
	// Curve constant d = -121665/121666 mod p.
	localparam logic [FE_W-1:0] D_CONST =
		255'h52036cee_2b6ffe73_8cc74079_7779e898_00700a4d_4141d8ab_75eb4dca_135978a3;
	// sqrt(-1) = 2^((p-1)/4) mod p.
	localparam logic [FE_W-1:0] SQRTM1 =
		255'h2b832480_4fc1df0b_2b4d0099_3dfbd7a7_2f431806_ad2fe478_c4ee1b27_4a0ea0b0;

	// Highest set bit of p-2 and of (p+3)/8.
	localparam logic [BIT_W-1:0] INV_TOP = 8'd254;
	localparam logic [BIT_W-1:0] ROOT_TOP = 8'd251;

	// Working-set slots in the element memory.
	localparam logic [SLOT_W-1:0] SL_Y = 4'd0;
	localparam logic [SLOT_W-1:0] SL_D = 4'd1;
	localparam logic [SLOT_W-1:0] SL_I = 4'd2;
	localparam logic [SLOT_W-1:0] SL_YY = 4'd3;
	localparam logic [SLOT_W-1:0] SL_U = 4'd4;
	localparam logic [SLOT_W-1:0] SL_V = 4'd5;
	localparam logic [SLOT_W-1:0] SL_R = 4'd6;
	localparam logic [SLOT_W-1:0] SL_X = 4'd7;
	localparam logic [SLOT_W-1:0] SL_T = 4'd8;
	localparam int MEM_DEPTH = 16;

	// Program locations the root check branches to.
	localparam logic [PC_W-1:0] PC_FIX = 4'd10;
	localparam logic [PC_W-1:0] PC_FIN = 4'd11;

	typedef enum logic [2:0] {
		OP_MUL,
		OP_SUB1,
		OP_ADD1,
		OP_COPY,
		OP_POW_INV,
		OP_POW_ROOT,
		OP_CHECK,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t op;
		logic [SLOT_W-1:0] dst;
		logic [SLOT_W-1:0] a;
		logic [SLOT_W-1:0] b;
	} inst_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_Y,
		ST_LD_D,
		ST_LD_I,
		ST_RD_A,
		ST_RD_B,
		ST_OPS,
		ST_MUL,
		ST_MACC,
		ST_RED1,
		ST_RED2,
		ST_WB,
		ST_ALU,
		ST_DONE
	} state_t;

	function automatic inst_t prog(input logic [PC_W-1:0] pc);
		inst_t i;
		i = '{op: OP_FIN, dst: SL_X, a: SL_X, b: SL_X};
		unique case (pc)
			4'd0: i = '{op: OP_MUL, dst: SL_YY, a: SL_Y, b: SL_Y};
			4'd1: i = '{op: OP_SUB1, dst: SL_U, a: SL_YY, b: SL_YY};
			4'd2: i = '{op: OP_MUL, dst: SL_T, a: SL_D, b: SL_YY};
			4'd3: i = '{op: OP_ADD1, dst: SL_V, a: SL_T, b: SL_T};
			4'd4: i = '{op: OP_POW_INV, dst: SL_R, a: SL_V, b: SL_V};
			4'd5: i = '{op: OP_MUL, dst: SL_R, a: SL_U, b: SL_R};
			4'd6: i = '{op: OP_POW_ROOT, dst: SL_X, a: SL_R, b: SL_R};
			4'd7: i = '{op: OP_MUL, dst: SL_T, a: SL_X, b: SL_X};
			4'd8: i = '{op: OP_MUL, dst: SL_T, a: SL_T, b: SL_V};
			4'd9: i = '{op: OP_CHECK, dst: SL_T, a: SL_T, b: SL_U};
			4'd10: i = '{op: OP_MUL, dst: SL_X, a: SL_X, b: SL_I};
			default: i = '{op: OP_FIN, dst: SL_X, a: SL_X, b: SL_X};
		endcase
		return i;
	endfunction

	// Exponent bits below the top bit: p-2 has zeros at bits 2 and 4,
	// (p+3)/8 = 2^252 - 2 has a zero at bit 0.
	function automatic logic pow_bit(input logic root, input logic [BIT_W-1:0] idx);
		if (root) begin
			return idx != 8'd0;
		end
		return (idx != 8'd2) && (idx != 8'd4);
	endfunction

endpackage

// File: sv/edpd_ram.sv
// ----------------------------------------------------------------------------
// edpd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module edpd_ram #(
	parameter int WIDTH = 255,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/edwards25519_point_decompress_top.sv
// ----------------------------------------------------------------------------
// edwards25519_point_decompress_top: compressed point to affine (x, y)
// Microcoded field engine over a small element memory with one multiplier row.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Beat contents
// s_axis   in   tdata[255:0]: enc_word0..enc_word3, bit 255 is the sign of x
// m_axis   out  tdata[509:0]: x (bits 254:0), y (bits 509:255); tuser: point_valid
//
// Each accepted point runs through a fixed micro-program: y^2, u, v, a
// 254-step exponentiation for 1/v, a 251-step exponentiation for the root,
// the root check and the sign fix. One field multiplication runs through
// two memory reads, eight row products through eight 32x32 multipliers, one
// accumulate, two fold steps and a write-back; a non-canonical y goes from
// the load of y straight to the done state. Reset clears the control state
// only. The input has a one-beat buffer and the result sits in an output
// register, so the next point is taken while a finished result waits on a
// stalled m_axis.
//
module edwards25519_point_decompress_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// enc_word0 [63:0], enc_word1 [127:64], enc_word2 [191:128], enc_word3 [255:192]
	input  logic [255:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// x_word0..x_word3 [254:0], y_word0..y_word3 [509:255], zero [511:510]
	output logic [511:0] m_axis_tdata,
	// point_valid [0]
	output logic         m_axis_tuser
);

	localparam int FE_W = edpd_pkg::FE_W;

	edpd_pkg::state_t state_q, state_d;

	logic [edpd_pkg::PC_W-1:0]   pc_q;
	logic                        pw_init_q;
	logic                        pw_mulb_q;
	logic [edpd_pkg::BIT_W-1:0]  bidx_q;
	logic [2:0]                  mcnt_q;
	logic                        ibuf_v_q;
	logic                        out_valid_q;

	logic [255:0]      ibuf_q;
	logic [FE_W-1:0]   y_q;
	logic              sign_q;
	logic [FE_W-1:0]   opa_q;
	logic [FE_W-1:0]   opb_q;
	logic [287:0]      prod_s1;
	logic [511:0]      acc_q;
	logic [260:0]      red_q;
	logic [FE_W-1:0]   res_x_q;
	logic              res_ok_q;
	logic [509:0]      out_data_q;
	logic              out_ok_q;

	// Handshake
	logic in_acc;
	logic out_free;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !ibuf_v_q;
	assign out_free = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {2'b00, out_data_q};
	assign m_axis_tuser = out_ok_q;

	// Instruction decode. An exponentiation expands into a copy of the base
	// followed by square and multiply-by-base steps, one exponent bit at a time.
	edpd_pkg::inst_t inst;
	edpd_pkg::op_t eff_op;
	logic [edpd_pkg::SLOT_W-1:0] rd_a, rd_b;
	logic is_pow, is_root, pbit;
	logic [edpd_pkg::BIT_W-1:0] ptop;

	always_comb begin
		inst = edpd_pkg::prog(pc_q);
		is_pow = (inst.op == edpd_pkg::OP_POW_INV) || (inst.op == edpd_pkg::OP_POW_ROOT);
		is_root = inst.op == edpd_pkg::OP_POW_ROOT;
		ptop = is_root ? edpd_pkg::ROOT_TOP : edpd_pkg::INV_TOP;
		pbit = edpd_pkg::pow_bit(is_root, bidx_q);
		eff_op = inst.op;
		rd_a = inst.a;
		rd_b = inst.b;
		if (is_pow) begin
			if (pw_init_q) begin
				eff_op = edpd_pkg::OP_COPY;
			end else if (pw_mulb_q) begin
				eff_op = edpd_pkg::OP_MUL;
				rd_a = inst.dst;
				rd_b = inst.a;
			end else begin
				eff_op = edpd_pkg::OP_MUL;
				rd_a = inst.dst;
				rd_b = inst.dst;
			end
		end
	end

	// Row product: one 32-bit limb of a times all of b. Even and odd partial
	// products do not overlap within their row, so one add merges them.
	logic [255:0] opa_ext, opb_ext;
	logic [31:0]  limb;
	logic [63:0]  pp [8];
	logic [287:0] prod_d;
	assign opa_ext = {1'b0, opa_q};
	assign opb_ext = {1'b0, opb_q};
	assign limb = opa_ext[mcnt_q*32 +: 32];

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			pp[j] = limb * opb_ext[j*32 +: 32];
		end
		prod_d = {32'b0, pp[6], pp[4], pp[2], pp[0]} + {pp[7], pp[5], pp[3], pp[1], 32'b0};
	end

	// Reduction: 2^255 = 19 mod p, folded twice, then one conditional subtract.
	logic [254:0] hi;
	logic [260:0] red1_d;
	logic [10:0]  t19;
	logic [255:0] red2_d;
	logic [255:0] wb_v;
	logic [FE_W-1:0] wb_val;
	assign hi = acc_q[509:255];
	assign red1_d = {6'b0, acc_q[254:0]} + {2'b0, hi, 4'b0} + {5'b0, hi, 1'b0} + {6'b0, hi};
	assign t19 = {5'b0, red_q[260:255]} * 11'd19;
	assign red2_d = {1'b0, red_q[254:0]} + {245'b0, t19};
	assign wb_v = red_q[255:0];
	assign wb_val = (wb_v >= {1'b0, edpd_pkg::P}) ? FE_W'(wb_v - {1'b0, edpd_pkg::P})
		: wb_v[254:0];

	// Small field operations on the loaded operands.
	logic [FE_W-1:0] sub1, add1, mu, negx, fin_x, alu_val;
	logic eq_u, eq_mu, fin_bad;
	always_comb begin
		sub1 = (opa_q == '0) ? edpd_pkg::P - FE_W'(1) : opa_q - FE_W'(1);
		add1 = (opa_q == edpd_pkg::P - FE_W'(1)) ? '0 : opa_q + FE_W'(1);
		mu = (opb_q == '0) ? '0 : edpd_pkg::P - opb_q;
		negx = (opa_q == '0) ? '0 : edpd_pkg::P - opa_q;
		eq_u = opa_q == opb_q;
		eq_mu = opa_q == mu;
		fin_bad = (opa_q == '0) && sign_q;
		fin_x = (opa_q[0] != sign_q) ? negx : opa_q;
		unique case (eff_op)
			edpd_pkg::OP_SUB1: alu_val = sub1;
			edpd_pkg::OP_ADD1: alu_val = add1;
			default:           alu_val = opa_q;
		endcase
	end

	// Element memory
	logic ram_we;
	logic [edpd_pkg::SLOT_W-1:0] ram_waddr, ram_raddr;
	logic [FE_W-1:0] ram_wdata, ram_rdata;
	logic alu_wr;
	assign alu_wr = (eff_op == edpd_pkg::OP_SUB1) || (eff_op == edpd_pkg::OP_ADD1)
		|| (eff_op == edpd_pkg::OP_COPY);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = inst.dst;
		ram_wdata = wb_val;
		ram_raddr = (state_q == edpd_pkg::ST_RD_B) ? rd_b : rd_a;
		unique case (state_q)
			edpd_pkg::ST_LD_Y: begin
				ram_we = 1'b1;
				ram_waddr = edpd_pkg::SL_Y;
				ram_wdata = ibuf_q[254:0];
			end
			edpd_pkg::ST_LD_D: begin
				ram_we = 1'b1;
				ram_waddr = edpd_pkg::SL_D;
				ram_wdata = edpd_pkg::D_CONST;
			end
			edpd_pkg::ST_LD_I: begin
				ram_we = 1'b1;
				ram_waddr = edpd_pkg::SL_I;
				ram_wdata = edpd_pkg::SQRTM1;
			end
			edpd_pkg::ST_WB: ram_we = 1'b1;
			edpd_pkg::ST_ALU: begin
				ram_we = alu_wr;
				ram_wdata = alu_val;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// Reads are issued only after the previous write-back, so a slot is never
	// read while its new value is still in flight.
	edpd_ram #(.WIDTH(FE_W), .DEPTH(edpd_pkg::MEM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			edpd_pkg::ST_IDLE: if (ibuf_v_q) state_d = edpd_pkg::ST_LD_Y;
			edpd_pkg::ST_LD_Y: begin
				state_d = (ibuf_q[254:0] >= edpd_pkg::P) ? edpd_pkg::ST_DONE
					: edpd_pkg::ST_LD_D;
			end
			edpd_pkg::ST_LD_D: state_d = edpd_pkg::ST_LD_I;
			edpd_pkg::ST_LD_I: state_d = edpd_pkg::ST_RD_A;
			edpd_pkg::ST_RD_A: state_d = edpd_pkg::ST_RD_B;
			edpd_pkg::ST_RD_B: state_d = edpd_pkg::ST_OPS;
			edpd_pkg::ST_OPS: begin
				state_d = (eff_op == edpd_pkg::OP_MUL) ? edpd_pkg::ST_MUL : edpd_pkg::ST_ALU;
			end
			edpd_pkg::ST_MUL: if (mcnt_q == 3'd0) state_d = edpd_pkg::ST_MACC;
			edpd_pkg::ST_MACC: state_d = edpd_pkg::ST_RED1;
			edpd_pkg::ST_RED1: state_d = edpd_pkg::ST_RED2;
			edpd_pkg::ST_RED2: state_d = edpd_pkg::ST_WB;
			edpd_pkg::ST_WB: state_d = edpd_pkg::ST_RD_A;
			edpd_pkg::ST_ALU: begin
				priority if (eff_op == edpd_pkg::OP_FIN) begin
					state_d = edpd_pkg::ST_DONE;
				end else if (eff_op == edpd_pkg::OP_CHECK) begin
					state_d = (eq_u || eq_mu) ? edpd_pkg::ST_RD_A : edpd_pkg::ST_DONE;
				end else begin
					state_d = edpd_pkg::ST_RD_A;
				end
			end
			edpd_pkg::ST_DONE: if (out_free) state_d = edpd_pkg::ST_IDLE;
			default: state_d = edpd_pkg::ST_IDLE;
		endcase
	end

	logic step_done;
	assign step_done = (state_q == edpd_pkg::ST_WB)
		|| ((state_q == edpd_pkg::ST_ALU) && alu_wr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= edpd_pkg::ST_IDLE;
			pc_q <= '0;
			pw_init_q <= 1'b1;
			pw_mulb_q <= 1'b0;
			bidx_q <= '0;
			mcnt_q <= '0;
			ibuf_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				ibuf_v_q <= 1'b1;
			end else if (state_q == edpd_pkg::ST_IDLE && ibuf_v_q) begin
				ibuf_v_q <= 1'b0;
			end
			if (state_q == edpd_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == edpd_pkg::ST_OPS) begin
				mcnt_q <= 3'd7;
			end else if (state_q == edpd_pkg::ST_MUL) begin
				mcnt_q <= mcnt_q - 3'd1;
			end
			if (state_q == edpd_pkg::ST_LD_I) begin
				pc_q <= '0;
				pw_init_q <= 1'b1;
				pw_mulb_q <= 1'b0;
			end else if (state_q == edpd_pkg::ST_ALU && eff_op == edpd_pkg::OP_CHECK) begin
				pc_q <= eq_u ? edpd_pkg::PC_FIN : edpd_pkg::PC_FIX;
				pw_init_q <= 1'b1;
			end else if (step_done) begin
				if (is_pow && pw_init_q) begin
					pw_init_q <= 1'b0;
					pw_mulb_q <= 1'b0;
					bidx_q <= ptop - 8'd1;
				end else if (is_pow && !pw_mulb_q && pbit) begin
					pw_mulb_q <= 1'b1;
				end else if (is_pow && bidx_q != 8'd0) begin
					pw_mulb_q <= 1'b0;
					bidx_q <= bidx_q - 8'd1;
				end else begin
					pw_mulb_q <= 1'b0;
					pc_q <= pc_q + 4'd1;
					pw_init_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ibuf_q <= s_axis_tdata;
		end
		unique case (state_q)
			edpd_pkg::ST_LD_Y: begin
				y_q <= ibuf_q[254:0];
				sign_q <= ibuf_q[255];
				res_x_q <= '0;
				res_ok_q <= 1'b0;
			end
			edpd_pkg::ST_RD_B: opa_q <= ram_rdata;
			edpd_pkg::ST_OPS: begin
				opb_q <= ram_rdata;
				prod_s1 <= '0;
				acc_q <= '0;
			end
			edpd_pkg::ST_MUL, edpd_pkg::ST_MACC: begin
				prod_s1 <= prod_d;
				acc_q <= {acc_q[479:0], 32'b0} + {224'b0, prod_s1};
			end
			edpd_pkg::ST_RED1: red_q <= red1_d;
			edpd_pkg::ST_RED2: red_q <= {5'b0, red2_d};
			edpd_pkg::ST_ALU: begin
				if (eff_op == edpd_pkg::OP_FIN) begin
					res_ok_q <= !fin_bad;
					res_x_q <= fin_bad ? '0 : fin_x;
				end
			end
			edpd_pkg::ST_DONE: begin
				if (out_free) begin
					out_data_q <= res_ok_q ? {y_q, res_x_q} : '0;
					out_ok_q <= res_ok_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Assertions
	a_wb_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == edpd_pkg::ST_WB |-> wb_val < edpd_pkg::P)
		else $error("write-back value not reduced");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == edpd_pkg::ST_DONE))
		else $error("result raised outside the done state");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ok_q |-> out_data_q == '0)
		else $error("rejected point carries nonzero coordinates");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == edpd_pkg::ST_LD_Y || state_q == edpd_pkg::ST_LD_D
			|| state_q == edpd_pkg::ST_LD_I || state_q == edpd_pkg::ST_WB
			|| state_q == edpd_pkg::ST_ALU))
		else $error("element memory written outside a write state");

endmodule

// File: tb/tb_edwards25519_point_decompress_top.sv
// ----------------------------------------------------------------------------
// tb_edwards25519_point_decompress_top: point decompression testbench
// Drives compressed points into s_axis, predicts (x, y, valid) with a
// behavioral field model and checks each m_axis beat in order, under
// several idle and stall mixes plus one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_edwards25519_point_decompress_top;

	localparam int FE_W = edpd_pkg::FE_W;
	localparam int MAX_CYCLES = 20_000_000;
	localparam int TAIL_CYCLES = 64;
	localparam int HOLD_CYCLES = 60_000;
	localparam int MAX_REPORTS = 10;

	// Exponents derived from the prime itself.
	localparam logic [FE_W-1:0] E_INV = edpd_pkg::P - 255'd2;
	localparam logic [FE_W-1:0] E_ROOT = (edpd_pkg::P + 255'd3) >> 3;
	localparam logic [FE_W-1:0] E_QUARTER = (edpd_pkg::P - 255'd1) >> 2;

	typedef struct {
		logic [FE_W-1:0] x;
		logic [FE_W-1:0] y;
		logic            ok;
	} affine_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [511:0] m_axis_tdata;
	logic         m_axis_tuser;

	affine_t      pending_points[$];
	int           mismatches;
	int           checked_beats;
	int           sent_points;
	int           decoded_points;
	int           cycle_count;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           hold_left;
	logic [FE_W-1:0] curve_d;
	logic [FE_W-1:0] root_m1;

	edwards25519_point_decompress_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Field arithmetic mod p on plain wide vectors.
	// ------------------------------------------------------------------
	function automatic logic [FE_W-1:0] fmul(input logic [FE_W-1:0] a, input logic [FE_W-1:0] b);
		logic [2*FE_W-1:0] t;
		t = {{FE_W{1'b0}}, a} * {{FE_W{1'b0}}, b};
		t = t % {{FE_W{1'b0}}, edpd_pkg::P};
		return t[FE_W-1:0];
	endfunction

	function automatic logic [FE_W-1:0] fsub(input logic [FE_W-1:0] a, input logic [FE_W-1:0] b);
		logic [FE_W:0] t;
		if (a >= b) begin
			t = {1'b0, a} - {1'b0, b};
		end else begin
			t = {1'b0, a} + {1'b0, edpd_pkg::P} - {1'b0, b};
		end
		return t[FE_W-1:0];
	endfunction

	function automatic logic [FE_W-1:0] fadd(input logic [FE_W-1:0] a, input logic [FE_W-1:0] b);
		logic [FE_W:0] t;
		t = {1'b0, a} + {1'b0, b};
		if (t >= {1'b0, edpd_pkg::P}) begin
			t = t - {1'b0, edpd_pkg::P};
		end
		return t[FE_W-1:0];
	endfunction

	function automatic logic [FE_W-1:0] fpow(input logic [FE_W-1:0] base, input logic [FE_W-1:0] e);
		logic [FE_W-1:0] r;
		r = FE_W'(1);
		for (int i = FE_W - 1; i >= 0; i--) begin
			r = fmul(r, r);
			if (e[i]) begin
				r = fmul(r, base);
			end
		end
		return r;
	endfunction

	// Full decode of one encoding: canonical check, ratio root, the
	// sqrt(-1) correction, then the sign rule.
	function automatic affine_t predict_point(input logic [255:0] enc);
		affine_t res;
		logic [FE_W-1:0] y, yy, u, v, x, vx2;
		logic sign;
		res.x = '0;
		res.y = '0;
		res.ok = 1'b0;
		y = enc[FE_W-1:0];
		sign = enc[255];
		if (y >= edpd_pkg::P) begin
			return res;
		end
		yy = fmul(y, y);
		u = fsub(yy, 255'd1);
		v = fadd(fmul(curve_d, yy), 255'd1);
		x = fpow(fmul(u, fpow(v, E_INV)), E_ROOT);
		vx2 = fmul(fmul(x, x), v);
		if (vx2 != u) begin
			if (vx2 == fsub(255'd0, u)) begin
				x = fmul(x, root_m1);
			end else begin
				return res;
			end
		end
		if (x == '0 && sign) begin
			return res;
		end
		if (x[0] != sign) begin
			x = fsub(255'd0, x);
		end
		res.x = x;
		res.y = y;
		res.ok = 1'b1;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Cycle counter and watchdog.
	// ------------------------------------------------------------------
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > MAX_CYCLES) begin
				$display("timeout after %0d cycles, %0d results still due",
					cycle_count, pending_points.size());
				$display("edwards25519_point_decompress_top test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off counted down here.
	// ------------------------------------------------------------------
	initial begin
		m_axis_tready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every output beat against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		affine_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected result beat: tdata=%h tuser=%b",
						m_axis_tdata, m_axis_tuser);
				end
			end else begin
				want = pending_points.pop_front();
				checked_beats++;
				if (m_axis_tdata[254:0] !== want.x || m_axis_tdata[509:255] !== want.y ||
						m_axis_tdata[511:510] !== 2'b00 || m_axis_tuser !== want.ok) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("result %0d mismatch", checked_beats);
						$display("  x exp %h got %h", want.x, m_axis_tdata[254:0]);
						$display("  y exp %h got %h", want.y, m_axis_tdata[509:255]);
						$display("  valid exp %b got %b, pad %b", want.ok, m_axis_tuser,
							m_axis_tdata[511:510]);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender. Returns at the rising edge where the beat was accepted, so
	// the next call makes the only assignment of the following low phase.
	// ------------------------------------------------------------------
	task automatic send_point(input logic [255:0] enc);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= enc;
		forever begin
			@(posedge clk);
			if (s_axis_tready) begin
				break;
			end
		end
		pending_points.push_back(predict_point(enc));
		sent_points++;
		if (pending_points[$].ok) begin
			decoded_points++;
		end
	endtask

	// Lowers valid and waits until every prediction has been matched.
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic [255:0] random_word256();
		logic [255:0] w;
		for (int i = 0; i < 8; i++) begin
			w[32*i +: 32] = $urandom;
		end
		return w;
	endfunction

	// Mostly full random encodings, with some edge values of y mixed in.
	function automatic logic [255:0] random_point();
		logic [255:0] enc;
		int pick;
		enc = random_word256();
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			enc[254:0] = edpd_pkg::P + 255'($urandom_range(0, 18));
		end else if (pick < 10) begin
			case ($urandom_range(0, 2))
				0: enc[254:0] = 255'd0;
				1: enc[254:0] = 255'd1;
				default: enc[254:0] = edpd_pkg::P - 255'd1;
			endcase
		end
		return enc;
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------
	task automatic test_directed();
		logic [FE_W-1:0] base_y;
		// Base point y = 4/5.
		base_y = fmul(255'd4, fpow(255'd5, E_INV));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_point({1'b0, base_y});
		send_point({1'b1, base_y});
		// y = 0 needs the sqrt(-1) fix-up.
		send_point({1'b0, 255'd0});
		send_point({1'b1, 255'd0});
		// u = 0: both root tests hold and x stays zero.
		send_point({1'b0, 255'd1});
		send_point({1'b0, edpd_pkg::P - 255'd1});
		// Zero x with the sign bit set is rejected.
		send_point({1'b1, 255'd1});
		send_point({1'b1, edpd_pkg::P - 255'd1});
		// Non-canonical y.
		send_point({1'b0, edpd_pkg::P});
		send_point({1'b1, edpd_pkg::P + 255'd1});
		send_point({1'b0, edpd_pkg::P + 255'd18});
		send_point({256{1'b1}});
		// Small y values, some without a square root.
		send_point({1'b0, 255'd2});
		send_point({1'b1, 255'd3});
		send_point({1'b0, edpd_pkg::P - 255'd2});
		drain_results();
	endtask

	task automatic test_random(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			send_point(random_point());
		end
		drain_results();
	endtask

	// The output is held off long enough that the result register and
	// the input buffer both fill and s_axis_tready drops.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_left = HOLD_CYCLES;
		repeat (4) begin
			send_point(random_point());
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		checked_beats = 0;
		sent_points = 0;
		decoded_points = 0;
		curve_d = fmul(fsub(255'd0, 255'd121665), fpow(255'd121666, E_INV));
		root_m1 = fpow(255'd2, E_QUARTER);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(30, 0, 0);
		test_random(30, 51, 0);
		test_random(30, 0, 51);
		test_random(30, 10, 10);
		test_backpressure();

		$display("covered %0d points (%0d decoded, %0d rejected), %0d beats checked",
			sent_points, decoded_points, sent_points - decoded_points, checked_beats);
		$display("idle and stall mixes plus one long output hold-off, %0d cycles",
			cycle_count);
		if (mismatches == 0 && pending_points.size() == 0) begin
			$display("edwards25519_point_decompress_top test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("edwards25519_point_decompress_top test failed");
		end
		$finish;
	end

endmodule

// File: edwards25519_point_decompress_top.f
sv/edpd_pkg.sv
sv/edpd_ram.sv
sv/edwards25519_point_decompress_top.sv
tb/tb_edwards25519_point_decompress_top.sv
